@@ hw/rtl/address_claim_arbiter_assert.svh @@
// assertion macros shared by the address claim arbiter modules
`ifndef ADDRESS_CLAIM_ARBITER_ASSERT_SVH
`define ADDRESS_CLAIM_ARBITER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define ACA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("address claim arbiter check failed");

// next-cycle implication, sampled on clock, off during reset
`define ACA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("address claim arbiter check failed");

`endif

@@ hw/rtl/aca_pkg.sv @@
// shared types, constants and microcode table of the address claim arbiter
`default_nettype none

package aca_pkg;

   // machine states
   localparam logic [2:0] ST_UNDEF         = 3'd0;
   localparam logic [2:0] ST_INIT          = 3'd1;
   localparam logic [2:0] ST_WAIT          = 3'd2;
   localparam logic [2:0] ST_DELAY_RECLAIM = 3'd3;
   localparam logic [2:0] ST_CANNOT        = 3'd4;
   localparam logic [2:0] ST_DELAY_CANNOT  = 3'd5;
   localparam logic [2:0] ST_NORMAL        = 3'd6;
   localparam logic [2:0] ST_ILLEGAL       = 3'd7;

   // item modes
   localparam logic [2:0] MODE_TICK       = 3'd0;
   localparam logic [2:0] MODE_REQUEST    = 3'd1;
   localparam logic [2:0] MODE_OWN_ADDR   = 3'd2;
   localparam logic [2:0] MODE_CONTENTION = 3'd3;
   localparam logic [2:0] MODE_RESTART    = 3'd4;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_CA_NAME       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_MS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PREFERRED     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_STATE = 2'd3;

   // protocol constants
   localparam logic [7:0] CONTENTION_TIMEOUT = 8'd250;
   localparam logic [7:0] NULL_ADDR          = 8'd254;
   localparam logic [7:0] LAST_ADDR          = 8'd247;
   localparam logic [7:0] RST_NEXT_ADDR      = 8'd127;
   localparam logic [7:0] BACKOFF_MAX        = 8'd255;
   localparam logic [8:0] NAME_MODULUS       = 9'd255;

   // register reset values
   localparam logic [63:0] RST_CA_NAME       = 64'd0;
   localparam logic [7:0]  RST_TICK_MS       = 8'd10;
   localparam logic [7:0]  RST_PREFERRED     = 8'd128;
   localparam logic [2:0]  RST_INITIAL_STATE = ST_INIT;

   // back-off divider: 11-bit dividend, one quotient bit per step
   localparam int DIV_BITS  = 11;
   localparam int DIV_CNT_W = 4;

   typedef struct packed {
      logic [63:0] ca_name;
      logic [7:0]  tick_ms;
      logic [7:0]  preferred_address;
      logic [2:0]  initial_state;
   } cfg_type;

   // micro-operations
   typedef logic [2:0] uop_type;
   localparam uop_type OP_NOP      = 3'd0;
   localparam uop_type OP_EVENT    = 3'd1;
   localparam uop_type OP_TICK     = 3'd2;
   localparam uop_type OP_DIV_LOAD = 3'd3;
   localparam uop_type OP_DIV_STEP = 3'd4;
   localparam uop_type OP_FINISH   = 3'd5;

   // jump conditions
   typedef logic [2:0] cond_type;
   localparam cond_type CND_NEVER      = 3'd0;
   localparam cond_type CND_ALWAYS     = 3'd1;
   localparam cond_type CND_NOT_TICK   = 3'd2;
   localparam cond_type CND_NEED_DELAY = 3'd3;
   localparam cond_type CND_DIV_MORE   = 3'd4;
   localparam cond_type CND_OUT_BUSY   = 3'd5;

   // program steps
   typedef logic [2:0] step_type;
   localparam step_type STEP_DISPATCH   = 3'd0;
   localparam step_type STEP_TEST       = 3'd1;
   localparam step_type STEP_TICK       = 3'd2;
   localparam step_type STEP_DIV_LOAD   = 3'd3;
   localparam step_type STEP_DIV_LOOP   = 3'd4;
   localparam step_type STEP_TICK_DELAY = 3'd5;
   localparam step_type STEP_FINISH     = 3'd6;
   localparam step_type STEP_SPARE      = 3'd7;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target;
      logic     last;
   } ctrl_type;

   // datapath status seen by the jump logic
   typedef struct packed {
      logic not_tick;
      logic need_delay;
      logic div_more;
      logic out_busy;
   } stat_type;

   // the microprogram
   function automatic ctrl_type ucode_rom(input step_type step);
      ctrl_type word;
      case (step)
         STEP_DISPATCH:   word = '{OP_EVENT,    CND_NOT_TICK,   STEP_FINISH,   1'b0};
         STEP_TEST:       word = '{OP_NOP,      CND_NEED_DELAY, STEP_DIV_LOAD, 1'b0};
         STEP_TICK:       word = '{OP_TICK,     CND_ALWAYS,     STEP_FINISH,   1'b0};
         STEP_DIV_LOAD:   word = '{OP_DIV_LOAD, CND_NEVER,      STEP_DIV_LOOP, 1'b0};
         STEP_DIV_LOOP:   word = '{OP_DIV_STEP, CND_DIV_MORE,   STEP_DIV_LOOP, 1'b0};
         STEP_TICK_DELAY: word = '{OP_TICK,     CND_ALWAYS,     STEP_FINISH,   1'b0};
         STEP_FINISH:     word = '{OP_FINISH,   CND_OUT_BUSY,   STEP_FINISH,   1'b1};
         default:         word = '{OP_NOP,      CND_NEVER,      STEP_DISPATCH, 1'b1};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aca_if.sv @@
// handshake channels of the address claim arbiter: request, response, csr
`default_nettype none

interface aca_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [63:0] contender_name;
   logic        tx_ok;
   logic        bus_off;
   modport source (output valid, mode, contender_name, tx_ok, bus_off, input ready);
   modport sink   (input valid, mode, contender_name, tx_ok, bus_off, output ready);
endinterface

interface aca_rsp_if;
   logic       valid;
   logic       ready;
   logic       claim_sent;
   logic [7:0] claim_address;
   logic [2:0] state_code;
   logic       address_claimed;
   modport source (output valid, claim_sent, claim_address, state_code, address_claimed,
                   input ready);
   modport sink   (input valid, claim_sent, claim_address, state_code, address_claimed,
                   output ready);
endinterface

interface aca_csr_if;
   logic                          valid;
   logic                          ready;
   logic [aca_pkg::CSR_IDX_W-1:0] index;
   logic [63:0]                   wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/aca_sequencer.sv @@
// step counter, microcode lookup and conditional jumps
`default_nettype none
`include "address_claim_arbiter_assert.svh"

module aca_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire aca_pkg::stat_type stat,
   output aca_pkg::uop_type       uop,
   output logic                   busy
);

   logic              run_ff;
   logic              run_in;
   aca_pkg::step_type step_ff;
   aca_pkg::step_type step_in;
   aca_pkg::ctrl_type word;
   logic              hit;

   // control word of the current step
   assign word = aca_pkg::ucode_rom(step_ff);
   assign uop  = run_ff ? word.op : aca_pkg::OP_NOP;
   assign busy = run_ff;

   // jump condition select
   always_comb begin
      case (word.cond)
         aca_pkg::CND_NEVER:      hit = 1'b0;
         aca_pkg::CND_ALWAYS:     hit = 1'b1;
         aca_pkg::CND_NOT_TICK:   hit = stat.not_tick;
         aca_pkg::CND_NEED_DELAY: hit = stat.need_delay;
         aca_pkg::CND_DIV_MORE:   hit = stat.div_more;
         aca_pkg::CND_OUT_BUSY:   hit = stat.out_busy;
         default:                 hit = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      if (!run_ff) begin
         run_in  = start;
         step_in = aca_pkg::STEP_DISPATCH;
      end else if (hit) begin
         step_in = word.target;
      end else if (word.last) begin
         run_in = 1'b0;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= aca_pkg::STEP_DISPATCH;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   `ACA_ASSERT_NOW(a_step_in_program, run_ff, step_ff != aca_pkg::STEP_SPARE)
   `ACA_ASSERT_NEXT(a_start_enters_dispatch, start && !run_ff,
                    run_ff && step_ff == aca_pkg::STEP_DISPATCH)

endmodule

`default_nettype wire

@@ hw/rtl/aca_datapath.sv @@
// claim state registers, back-off divider and response register
`default_nettype none
`include "address_claim_arbiter_assert.svh"

module aca_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire aca_pkg::cfg_type  cfg,
   input  wire logic              start,
   input  wire logic [2:0]        req_mode,
   input  wire logic [63:0]       req_contender_name,
   input  wire logic              req_tx_ok,
   input  wire logic              req_bus_off,
   input  wire aca_pkg::uop_type  uop,
   output aca_pkg::stat_type      stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_claim_sent,
   output logic [7:0]             rsp_claim_address,
   output logic [2:0]             rsp_state_code,
   output logic                   rsp_address_claimed
);

   // latched item
   logic [2:0]  mode_ff;
   logic [63:0] contender_ff;
   logic        tx_ok_ff;
   logic        bus_off_ff;

   // claim state
   logic [2:0]  state_ff, state_in;
   logic [7:0]  source_ff, source_in;
   logic [7:0]  next_ff, next_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  backoff_ff, backoff_in;
   logic        req_pend_ff, req_pend_in;
   logic        own_pend_ff, own_pend_in;
   logic        cont_pend_ff, cont_pend_in;
   logic        claimed_ff, claimed_in;
   logic [63:0] rival_ff, rival_in;
   logic        sent_ff, sent_in;

   // divider
   logic [aca_pkg::DIV_BITS-1:0]  quo_ff, quo_in;
   logic [7:0]                    rem_ff, rem_in;
   logic [aca_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_sent_ff;
   logic [7:0] rsp_addr_ff;
   logic [2:0] rsp_state_ff;
   logic       rsp_claimed_ff;

   logic [10:0] name_sum;
   logic [8:0]  name_fold;
   logic [7:0]  name_mod;
   logic [10:0] dividend;
   logic [8:0]  trial;
   logic [7:0]  delay_val;
   logic [7:0]  bumped_addr;
   logic        rival_wins;
   logic [2:0]  restart_state;
   logic        out_busy;

   // name byte sum folded mod 255, times 6
   always_comb begin
      name_sum = '0;
      for (int i = 0; i < 8; i++) begin
         name_sum = name_sum + {3'b000, cfg.ca_name[8*i +: 8]};
      end
      name_fold = {1'b0, name_sum[7:0]} + {6'b000000, name_sum[10:8]};
      name_mod  = (name_fold >= aca_pkg::NAME_MODULUS)
                  ? 8'(name_fold - aca_pkg::NAME_MODULUS) : name_fold[7:0];
      dividend  = {1'b0, name_mod, 2'b00} + {2'b00, name_mod, 1'b0};
   end

   assign trial      = {rem_ff, quo_ff[aca_pkg::DIV_BITS-1]};
   assign delay_val  = (cfg.tick_ms == 8'd0) ? aca_pkg::BACKOFF_MAX : quo_ff[7:0];
   assign bumped_addr = ((next_ff + 8'd1) > aca_pkg::LAST_ADDR)
                        ? aca_pkg::NULL_ADDR : (next_ff + 8'd1);
   assign rival_wins = (rival_ff <= cfg.ca_name);
   assign restart_state = (cfg.tick_ms == 8'd0 || cfg.initial_state == aca_pkg::ST_ILLEGAL)
                          ? aca_pkg::ST_UNDEF : cfg.initial_state;
   assign out_busy   = rsp_valid_ff && !rsp_ready;

   // status for the jump logic
   assign stat.not_tick   = (mode_ff != aca_pkg::MODE_TICK);
   assign stat.need_delay = (state_ff == aca_pkg::ST_WAIT && bus_off_ff) ||
                            (state_ff == aca_pkg::ST_CANNOT && req_pend_ff);
   assign stat.div_more   = (cnt_ff != aca_pkg::DIV_CNT_W'(1));
   assign stat.out_busy   = out_busy;

   // micro-operation execution
   always_comb begin
      state_in     = state_ff;
      source_in    = source_ff;
      next_in      = next_ff;
      count_in     = count_ff;
      backoff_in   = backoff_ff;
      req_pend_in  = req_pend_ff;
      own_pend_in  = own_pend_ff;
      cont_pend_in = cont_pend_ff;
      claimed_in   = claimed_ff;
      rival_in     = rival_ff;
      sent_in      = sent_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (uop)
         aca_pkg::OP_EVENT: begin
            sent_in = 1'b0;
            case (mode_ff)
               aca_pkg::MODE_REQUEST:  req_pend_in = 1'b1;
               aca_pkg::MODE_OWN_ADDR: own_pend_in = 1'b1;
               aca_pkg::MODE_CONTENTION: begin
                  rival_in     = contender_ff;
                  cont_pend_in = 1'b1;
               end
               aca_pkg::MODE_RESTART: begin
                  state_in     = restart_state;
                  source_in    = cfg.preferred_address;
                  next_in      = aca_pkg::RST_NEXT_ADDR;
                  count_in     = cfg.tick_ms;
                  backoff_in   = 8'd0;
                  req_pend_in  = 1'b0;
                  own_pend_in  = 1'b0;
                  cont_pend_in = 1'b0;
                  claimed_in   = 1'b0;
                  rival_in     = 64'd0;
               end
               default: ;
            endcase
         end
         aca_pkg::OP_TICK: begin
            case (state_ff)
               aca_pkg::ST_INIT: begin
                  if (tx_ok_ff) begin
                     sent_in  = 1'b1;
                     state_in = aca_pkg::ST_WAIT;
                  end
               end
               aca_pkg::ST_WAIT: begin
                  if (bus_off_ff) begin
                     count_in   = cfg.tick_ms;
                     backoff_in = delay_val;
                     state_in   = aca_pkg::ST_DELAY_RECLAIM;
                  end else if (cont_pend_ff) begin
                     count_in = cfg.tick_ms;
                     if (rival_wins) begin
                        next_in   = bumped_addr;
                        source_in = bumped_addr;
                        if (bumped_addr == aca_pkg::NULL_ADDR) state_in = aca_pkg::ST_CANNOT;
                     end
                     if (tx_ok_ff) begin
                        sent_in      = 1'b1;
                        cont_pend_in = 1'b0;
                     end
                  end else if (count_ff == aca_pkg::CONTENTION_TIMEOUT) begin
                     count_in   = cfg.tick_ms;
                     claimed_in = 1'b1;
                     state_in   = aca_pkg::ST_NORMAL;
                  end else begin
                     count_in = count_ff + cfg.tick_ms;
                  end
               end
               aca_pkg::ST_DELAY_RECLAIM, aca_pkg::ST_DELAY_CANNOT: begin
                  if (backoff_ff < cfg.tick_ms) begin
                     if (tx_ok_ff) begin
                        sent_in  = 1'b1;
                        state_in = (state_ff == aca_pkg::ST_DELAY_RECLAIM)
                                   ? aca_pkg::ST_WAIT : aca_pkg::ST_CANNOT;
                     end
                  end else begin
                     backoff_in = backoff_ff - cfg.tick_ms;
                  end
               end
               aca_pkg::ST_CANNOT: begin
                  if (req_pend_ff) begin
                     backoff_in  = delay_val;
                     req_pend_in = 1'b0;
                     state_in    = aca_pkg::ST_DELAY_CANNOT;
                  end
               end
               aca_pkg::ST_NORMAL: begin
                  if (req_pend_ff || own_pend_ff) begin
                     if (tx_ok_ff) begin
                        sent_in     = 1'b1;
                        req_pend_in = 1'b0;
                        own_pend_in = 1'b0;
                     end
                  end else if (cont_pend_ff) begin
                     if (rival_wins) begin
                        next_in   = bumped_addr;
                        source_in = bumped_addr;
                        if (bumped_addr == aca_pkg::NULL_ADDR) state_in = aca_pkg::ST_CANNOT;
                     end
                     if (tx_ok_ff) begin
                        sent_in      = 1'b1;
                        cont_pend_in = 1'b0;
                     end
                  end
               end
               default: ;
            endcase
         end
         aca_pkg::OP_DIV_LOAD: begin
            quo_in = dividend;
            rem_in = 8'd0;
            cnt_in = aca_pkg::DIV_CNT_W'(aca_pkg::DIV_BITS);
         end
         aca_pkg::OP_DIV_STEP: begin
            if (trial >= {1'b0, cfg.tick_ms}) begin
               rem_in = 8'(trial - {1'b0, cfg.tick_ms});
               quo_in = {quo_ff[aca_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[7:0];
               quo_in = {quo_ff[aca_pkg::DIV_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - aca_pkg::DIV_CNT_W'(1);
         end
         aca_pkg::OP_FINISH: begin
            if (!out_busy) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // item capture and divider registers
   always_ff @(posedge clock) begin
      if (start) begin
         mode_ff      <= req_mode;
         contender_ff <= req_contender_name;
         tx_ok_ff     <= req_tx_ok;
         bus_off_ff   <= req_bus_off;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   // claim state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aca_pkg::RST_INITIAL_STATE;
         source_ff    <= aca_pkg::RST_PREFERRED;
         next_ff      <= aca_pkg::RST_NEXT_ADDR;
         count_ff     <= aca_pkg::RST_TICK_MS;
         backoff_ff   <= 8'd0;
         req_pend_ff  <= 1'b0;
         own_pend_ff  <= 1'b0;
         cont_pend_ff <= 1'b0;
         claimed_ff   <= 1'b0;
         rival_ff     <= 64'd0;
         sent_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         source_ff    <= source_in;
         next_ff      <= next_in;
         count_ff     <= count_in;
         backoff_ff   <= backoff_in;
         req_pend_ff  <= req_pend_in;
         own_pend_ff  <= own_pend_in;
         cont_pend_ff <= cont_pend_in;
         claimed_ff   <= claimed_in;
         rival_ff     <= rival_in;
         sent_ff      <= sent_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded when the result is posted
   always_ff @(posedge clock) begin
      if (uop == aca_pkg::OP_FINISH && !out_busy) begin
         rsp_sent_ff    <= sent_ff;
         rsp_addr_ff    <= source_ff;
         rsp_state_ff   <= state_ff;
         rsp_claimed_ff <= claimed_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_claim_sent      = rsp_sent_ff;
   assign rsp_claim_address   = rsp_addr_ff;
   assign rsp_state_code      = rsp_state_ff;
   assign rsp_address_claimed = rsp_claimed_ff;

   `ACA_ASSERT_NOW(a_div_count_live, uop == aca_pkg::OP_DIV_STEP, cnt_ff != '0)
   `ACA_ASSERT_NEXT(a_finish_posts, uop == aca_pkg::OP_FINISH && !out_busy, rsp_valid_ff)
   `ACA_ASSERT_NEXT(a_event_clears_sent, uop == aca_pkg::OP_EVENT, !sent_ff)

endmodule

`default_nettype wire

@@ hw/rtl/address_claim_arbiter.sv @@
// top level of the address claim arbiter: csr registers, sequencer and datapath
`default_nettype none

// Address-claim state machine of one CAN node. Each request item is a tick or an
// event and yields exactly one response item with the send flag, current source
// address, state and claimed flag. Items are handled one at a time by a small
// microprogram: an event runs the dispatch and finish steps, a plain tick the
// dispatch, test, tick and finish steps, and a tick that computes a new back-off
// delay runs the 11-step shift-subtract divider that divides the name-derived delay
// by tick_ms. The finished response sits in an output register, so a new item is
// accepted while it waits; the program stalls on its last step only if that
// register still holds an untaken response. Register writes are always accepted
// and must only be issued while no item is in flight.
module address_claim_arbiter (
   input  wire logic  clock,
   input  wire logic  reset,
   aca_req_if.sink    req_ch,
   aca_rsp_if.source  rsp_ch,
   aca_csr_if.sink    csr_ch
);

   aca_pkg::cfg_type  cfg_ff;
   aca_pkg::cfg_type  cfg_in;
   aca_pkg::uop_type  uop;
   aca_pkg::stat_type stat;
   logic              busy;
   logic              start;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            aca_pkg::REG_CA_NAME:       cfg_in.ca_name           = csr_ch.wdata;
            aca_pkg::REG_TICK_MS:       cfg_in.tick_ms           = csr_ch.wdata[7:0];
            aca_pkg::REG_PREFERRED:     cfg_in.preferred_address = csr_ch.wdata[7:0];
            aca_pkg::REG_INITIAL_STATE: cfg_in.initial_state     = csr_ch.wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ca_name           <= aca_pkg::RST_CA_NAME;
         cfg_ff.tick_ms           <= aca_pkg::RST_TICK_MS;
         cfg_ff.preferred_address <= aca_pkg::RST_PREFERRED;
         cfg_ff.initial_state     <= aca_pkg::RST_INITIAL_STATE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request handshake
   assign req_ch.ready = !busy;
   assign start        = req_ch.valid && !busy;

   aca_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .uop   (uop),
      .busy  (busy)
   );

   aca_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .start               (start),
      .req_mode            (req_ch.mode),
      .req_contender_name  (req_ch.contender_name),
      .req_tx_ok           (req_ch.tx_ok),
      .req_bus_off         (req_ch.bus_off),
      .uop                 (uop),
      .stat                (stat),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_claim_sent      (rsp_ch.claim_sent),
      .rsp_claim_address   (rsp_ch.claim_address),
      .rsp_state_code      (rsp_ch.state_code),
      .rsp_address_claimed (rsp_ch.address_claimed)
   );

endmodule

`default_nettype wire

@@ bench/address_claim_arbiter_tb.sv @@
`timescale 1ns / 1ps
// testbench of the address claim arbiter: directed rows, random phases, predictor checks

module address_claim_arbiter_tb;

   // modes the block ignores
   localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] contender_name;
      logic        tx_ok;
      logic        bus_off;
   } claim_item_type;

   typedef struct packed {
      logic       claim_sent;
      logic [7:0] claim_address;
      logic [2:0] state_code;
      logic       address_claimed;
   } claim_reply_type;

   typedef struct {
      claim_item_type  item;
      logic            known;
      claim_reply_type reply;
   } directed_row_type;

   typedef struct {
      logic [63:0] ca_name;
      logic [7:0]  tick_ms;
      logic [7:0]  preferred;
      logic [2:0]  initial_state;
      bit          restart;
      int          items;
      int          contention_pct;
      int          restart_pct;
      int          gap_pct;
      int          stall_pct;
      bit          hold_off;
   } phase_type;

   logic clock;
   logic reset;

   aca_req_if req_ch ();
   aca_rsp_if rsp_ch ();
   aca_csr_if csr_ch ();

   address_claim_arbiter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // mirrored registers
   logic [63:0] cfg_name;
   logic [7:0]  cfg_tick;
   logic [7:0]  cfg_pref;
   logic [2:0]  cfg_init;

   // predicted node state
   logic [2:0]  node_state;
   logic [7:0]  node_addr;
   logic [7:0]  next_addr;
   logic [7:0]  contention_count;
   logic [7:0]  backoff;
   logic        request_pending;
   logic        own_addr_pending;
   logic        contention_pending;
   logic        claimed;
   logic [63:0] rival_name;

   claim_reply_type expected_replies[$];

   // directed expectation handed from the driver to the monitor
   logic            row_known;
   claim_reply_type row_reply;

   int  failures;
   int  items_sent;
   int  replies_checked;
   int  settings_used;
   int  normal_replies;
   int  cannot_replies;
   int  item_gap_pct;
   int  reply_stall_pct;
   bit  hold_off_start;
   int  quiet_cycles;

   // back-off delay from the name bytes
   function automatic logic [7:0] backoff_ticks();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < 8; i++) begin
         sum += cfg_name[8*i +: 8];
      end
      if (cfg_tick == 0) begin
         return aca_pkg::BACKOFF_MAX;
      end
      return 8'(((sum % aca_pkg::NAME_MODULUS) * 6) / cfg_tick);
   endfunction

   // state as after reset or restart, from the current registers
   function automatic void reload_node();
      node_state         = (cfg_tick != 0 && cfg_init != aca_pkg::ST_ILLEGAL)
                           ? cfg_init : aca_pkg::ST_UNDEF;
      node_addr          = cfg_pref;
      next_addr          = aca_pkg::RST_NEXT_ADDR;
      contention_count   = cfg_tick;
      backoff            = '0;
      request_pending    = 1'b0;
      own_addr_pending   = 1'b0;
      contention_pending = 1'b0;
      claimed            = 1'b0;
      rival_name         = '0;
   endfunction

   // a loss moves to the next address; returns whether the claim went out
   function automatic logic settle_contention(input logic tx_ok);
      if (rival_name <= cfg_name) begin
         next_addr = next_addr + 8'd1;
         if (next_addr > aca_pkg::LAST_ADDR) begin
            next_addr = aca_pkg::NULL_ADDR;
         end
         node_addr = next_addr;
         if (node_addr == aca_pkg::NULL_ADDR) begin
            node_state = aca_pkg::ST_CANNOT;
         end
      end
      if (tx_ok) begin
         contention_pending = 1'b0;
      end
      return tx_ok;
   endfunction

   // advance the node by one item and return its reply
   function automatic claim_reply_type predict_claim(input claim_item_type it);
      logic sent;
      sent = 1'b0;
      case (it.mode)
         aca_pkg::MODE_TICK: begin
            case (node_state)
               aca_pkg::ST_INIT: begin
                  sent = it.tx_ok;
                  if (it.tx_ok) begin
                     node_state = aca_pkg::ST_WAIT;
                  end
               end
               aca_pkg::ST_WAIT: begin
                  if (it.bus_off) begin
                     contention_count = cfg_tick;
                     backoff          = backoff_ticks();
                     node_state       = aca_pkg::ST_DELAY_RECLAIM;
                  end else if (contention_pending) begin
                     contention_count = cfg_tick;
                     sent             = settle_contention(it.tx_ok);
                  end else if (contention_count == aca_pkg::CONTENTION_TIMEOUT) begin
                     contention_count = cfg_tick;
                     claimed          = 1'b1;
                     node_state       = aca_pkg::ST_NORMAL;
                  end else begin
                     contention_count = contention_count + cfg_tick;
                  end
               end
               aca_pkg::ST_DELAY_RECLAIM, aca_pkg::ST_DELAY_CANNOT: begin
                  if (backoff < cfg_tick) begin
                     sent = it.tx_ok;
                     if (it.tx_ok) begin
                        node_state = (node_state == aca_pkg::ST_DELAY_RECLAIM)
                                     ? aca_pkg::ST_WAIT : aca_pkg::ST_CANNOT;
                     end
                  end else begin
                     backoff = backoff - cfg_tick;
                  end
               end
               aca_pkg::ST_CANNOT: begin
                  if (request_pending) begin
                     backoff         = backoff_ticks();
                     request_pending = 1'b0;
                     node_state      = aca_pkg::ST_DELAY_CANNOT;
                  end
               end
               aca_pkg::ST_NORMAL: begin
                  if (request_pending || own_addr_pending) begin
                     sent = it.tx_ok;
                     if (it.tx_ok) begin
                        request_pending  = 1'b0;
                        own_addr_pending = 1'b0;
                     end
                  end else if (contention_pending) begin
                     sent = settle_contention(it.tx_ok);
                  end
               end
               default: begin
               end
            endcase
         end
         aca_pkg::MODE_REQUEST: request_pending = 1'b1;
         aca_pkg::MODE_OWN_ADDR: own_addr_pending = 1'b1;
         aca_pkg::MODE_CONTENTION: begin
            rival_name         = it.contender_name;
            contention_pending = 1'b1;
         end
         aca_pkg::MODE_RESTART: reload_node();
         default: begin
         end
      endcase
      return '{sent, node_addr, node_state, claimed};
   endfunction

   function automatic directed_row_type make_row(input logic [2:0] mode,
                                                 input logic [63:0] name,
                                                 input logic tx_ok, input logic bus_off,
                                                 input logic known, input logic sent,
                                                 input logic [7:0] addr,
                                                 input logic [2:0] st,
                                                 input logic got_claim);
      directed_row_type r;
      r.item  = '{mode, name, tx_ok, bus_off};
      r.known = known;
      r.reply = '{sent, addr, st, got_claim};
      return r;
   endfunction

   function automatic phase_type make_phase(input logic [63:0] name, input logic [7:0] tick,
                                            input logic [7:0] pref, input logic [2:0] init,
                                            input bit restart, input int items,
                                            input int cont_pct, input int rst_pct,
                                            input int gap_pct, input int stall_pct,
                                            input bit hold_off);
      phase_type p;
      p = '{name, tick, pref, init, restart, items, cont_pct, rst_pct, gap_pct, stall_pct,
            hold_off};
      return p;
   endfunction

   // mostly ticks and contentions near our own name, some noise
   function automatic claim_item_type random_item(input int cont_pct, input int rst_pct);
      claim_item_type it;
      int             roll;
      roll              = $urandom_range(99);
      it.contender_name = {$urandom, $urandom};
      it.tx_ok          = ($urandom_range(99) < 85);
      it.bus_off        = ($urandom_range(99) < 4);
      if (roll < rst_pct) begin
         it.mode = aca_pkg::MODE_RESTART;
      end else if (roll < rst_pct + cont_pct) begin
         it.mode = aca_pkg::MODE_CONTENTION;
         case ($urandom_range(3))
            0: it.contender_name = cfg_name;
            1: it.contender_name = cfg_name - 64'd1;
            2: it.contender_name = cfg_name + 64'd1;
            default: begin
            end
         endcase
      end else if (roll < rst_pct + cont_pct + 6) begin
         it.mode = aca_pkg::MODE_REQUEST;
      end else if (roll < rst_pct + cont_pct + 12) begin
         it.mode = aca_pkg::MODE_OWN_ADDR;
      end else if (roll < rst_pct + cont_pct + 15) begin
         it.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      end else begin
         it.mode = aca_pkg::MODE_TICK;
      end
      return it;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls and one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_start) begin
            hold_left      = HOLD_OFF_CYCLES;
            hold_off_start = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= reply_stall_pct);
         end
      end
   end

   // monitor: check replies, predict accepted items, mirror register writes
   always @(posedge clock) begin : monitor
      claim_reply_type want;
      claim_reply_type got;
      claim_reply_type pred;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.claim_sent, rsp_ch.claim_address, rsp_ch.state_code,
                    rsp_ch.address_claimed};
            if (expected_replies.size() == 0) begin
               $error("reply with no item outstanding: %p", got);
               failures++;
            end else begin
               want = expected_replies.pop_front();
               replies_checked++;
               if (got.claim_sent !== want.claim_sent) begin
                  $error("claim_sent: expected %0d, got %0d", want.claim_sent, got.claim_sent);
                  failures++;
               end
               if (got.claim_address !== want.claim_address) begin
                  $error("claim_address: expected %0d, got %0d",
                         want.claim_address, got.claim_address);
                  failures++;
               end
               if (got.state_code !== want.state_code) begin
                  $error("state_code: expected %0d, got %0d", want.state_code, got.state_code);
                  failures++;
               end
               if (got.address_claimed !== want.address_claimed) begin
                  $error("address_claimed: expected %0d, got %0d",
                         want.address_claimed, got.address_claimed);
                  failures++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pred = predict_claim('{req_ch.mode, req_ch.contender_name, req_ch.tx_ok,
                                   req_ch.bus_off});
            if (pred.state_code == aca_pkg::ST_NORMAL) normal_replies++;
            if (pred.state_code == aca_pkg::ST_CANNOT) cannot_replies++;
            expected_replies.push_back(row_known ? row_reply : pred);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               aca_pkg::REG_CA_NAME:       cfg_name = csr_ch.wdata;
               aca_pkg::REG_TICK_MS:       cfg_tick = csr_ch.wdata[7:0];
               aca_pkg::REG_PREFERRED:     cfg_pref = csr_ch.wdata[7:0];
               aca_pkg::REG_INITIAL_STATE: cfg_init = csr_ch.wdata[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   // watchdog: cycles in which nothing moves on any channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d replies outstanding",
                     quiet_cycles, expected_replies.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // offer one item, with random gaps ahead of it
   task automatic send_item(input claim_item_type it, input logic known,
                            input claim_reply_type r);
      while ($urandom_range(99) < item_gap_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid          = 1'b1;
      req_ch.mode           = it.mode;
      req_ch.contender_name = it.contender_name;
      req_ch.tx_ok          = it.tx_ok;
      req_ch.bus_off        = it.bus_off;
      row_known             = known;
      row_reply             = r;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [aca_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.wdata = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // stop offering, wait for every reply, then let the block settle
   task automatic drain_replies();
      req_ch.valid = 1'b0;
      row_known    = 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      directed_row_type directed_rows[$];
      phase_type        phases[$];
      phase_type        ph;
      claim_item_type   it;
      int               counted;

      // known values on every input from the start
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.mode           = aca_pkg::MODE_TICK;
      req_ch.contender_name = '0;
      req_ch.tx_ok          = 1'b0;
      req_ch.bus_off        = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = aca_pkg::REG_CA_NAME;
      csr_ch.wdata          = '0;
      row_known             = 1'b0;
      row_reply             = '0;
      failures              = 0;
      items_sent            = 0;
      replies_checked       = 0;
      settings_used         = 1;
      normal_replies        = 0;
      cannot_replies        = 0;
      item_gap_pct          = 0;
      reply_stall_pct       = 0;
      hold_off_start        = 1'b0;
      quiet_cycles          = 0;

      cfg_name = aca_pkg::RST_CA_NAME;
      cfg_tick = aca_pkg::RST_TICK_MS;
      cfg_pref = aca_pkg::RST_PREFERRED;
      cfg_init = aca_pkg::RST_INITIAL_STATE;
      reload_node();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows on the reset registers: name zero, tick 10, address 128
      directed_rows.push_back(make_row(MODE_SPARE_LO, '0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd128,
                                       aca_pkg::ST_INIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b0, 1'b0, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_INIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b1, 1'b1,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      // contender with an equal name wins: first address from 128
      directed_rows.push_back(make_row(aca_pkg::MODE_CONTENTION, '0, 1'b0, 1'b0, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b1, 1'b1,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      // highest name loses, failed send keeps the contention pending
      directed_rows.push_back(make_row(aca_pkg::MODE_CONTENTION, '1, 1'b1, 1'b1, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b0, 1'b0, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b1, 1'b1,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      // bus off with zero delay, then reclaim
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '1, 1'b1, 1'b1, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_DELAY_RECLAIM, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b1, 1'b1,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_REQUEST, '0, 1'b1, 1'b1, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_OWN_ADDR, '1, 1'b0, 1'b1, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(MODE_SPARE_HI, '1, 1'b1, 1'b1, 1'b1, 1'b0, 8'd128,
                                       aca_pkg::ST_WAIT, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_RESTART, '0, 1'b0, 1'b0, 1'b1, 1'b0,
                                       8'd128, aca_pkg::ST_INIT, 1'b0));
      // rows left to the predictor
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_REQUEST, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_CONTENTION, 64'h8000_0000_0000_0001,
                                       1'b1, 1'b0, 1'b0, 1'b0, '0, aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b0, 1'b1, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(aca_pkg::MODE_TICK, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));
      directed_rows.push_back(make_row(MODE_SPARE_MID, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0,
                                       aca_pkg::ST_UNDEF, 1'b0));

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].reply);
      end
      drain_replies();

      // register settings and traffic mix per phase
      phases.push_back(make_phase(64'h0123_4567_89AB_CDEF, 8'd10, 8'd0, aca_pkg::ST_INIT,
                                  1'b1, 200, 15, 2, 0, 0, 1'b0));
      phases.push_back(make_phase('1, 8'd125, 8'd253, aca_pkg::ST_INIT, 1'b1, 400, 45, 0,
                                  77, 0, 1'b0));
      phases.push_back(make_phase('0, 8'd1, 8'd128, aca_pkg::ST_INIT, 1'b1, 200, 15, 1, 0,
                                  77, 1'b1));
      phases.push_back(make_phase({$urandom, $urandom}, 8'd255, 8'd77, aca_pkg::ST_NORMAL,
                                  1'b1, 200, 20, 3, 20, 20, 1'b0));
      // tick zero at run time, no restart: delays never expire
      phases.push_back(make_phase({$urandom, $urandom}, 8'd0, 8'd5, aca_pkg::ST_WAIT, 1'b0,
                                  100, 20, 0, 0, 0, 1'b0));
      phases.push_back(make_phase({$urandom, $urandom}, 8'd0, 8'd200, aca_pkg::ST_CANNOT,
                                  1'b1, 50, 20, 2, 20, 20, 1'b0));
      phases.push_back(make_phase({$urandom, $urandom}, 8'd50, 8'd100, aca_pkg::ST_ILLEGAL,
                                  1'b1, 50, 20, 0, 0, 77, 1'b0));
      phases.push_back(make_phase({$urandom, $urandom}, 8'($urandom_range(255, 1)),
                                  8'($urandom_range(253)), 3'($urandom_range(6)), 1'b1,
                                  280, 25, 2, 77, 0, 1'b0));
      phases.push_back(make_phase({$urandom, $urandom}, 8'd50, 8'd130,
                                  aca_pkg::ST_DELAY_RECLAIM, 1'b1, 60, 20, 2, 0, 0, 1'b0));
      phases.push_back(make_phase({$urandom, $urandom}, 8'd2, 8'd140, aca_pkg::ST_UNDEF,
                                  1'b1, 40, 20, 2, 20, 20, 1'b0));

      foreach (phases[p]) begin
         ph              = phases[p];
         item_gap_pct    = ph.gap_pct;
         reply_stall_pct = ph.stall_pct;
         write_reg(aca_pkg::REG_CA_NAME, ph.ca_name);
         write_reg(aca_pkg::REG_TICK_MS, {56'd0, ph.tick_ms});
         write_reg(aca_pkg::REG_PREFERRED, {56'd0, ph.preferred});
         write_reg(aca_pkg::REG_INITIAL_STATE, {61'd0, ph.initial_state});
         settings_used++;
         if (ph.restart) begin
            it = '{aca_pkg::MODE_RESTART, {$urandom, $urandom}, 1'b0, 1'b0};
            send_item(it, 1'b0, '0);
         end
         if (ph.hold_off) begin
            hold_off_start = 1'b1;
         end
         counted = 0;
         while (counted < ph.items) begin
            it = random_item(ph.contention_pct, ph.restart_pct);
            send_item(it, 1'b0, '0);
            if (it.mode <= aca_pkg::MODE_RESTART) counted++;
         end
         drain_replies();
      end

      if (expected_replies.size() != 0) begin
         $error("%0d replies never arrived", expected_replies.size());
         failures++;
      end
      $display("%0d items over %0d register settings, %0d replies checked, %0d mismatches",
               items_sent, settings_used, replies_checked, failures);
      $display("replies in normal traffic: %0d, in cannot claim: %0d",
               normal_replies, cannot_replies);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/aca_pkg.sv
hw/rtl/aca_if.sv
hw/rtl/aca_sequencer.sv
hw/rtl/aca_datapath.sv
hw/rtl/address_claim_arbiter.sv
bench/address_claim_arbiter_tb.sv
